// File: rtl/axbsm_pkg.sv
// Shared constants, codes and types of the AXI4 burst slave with transmit register.
package axbsm_pkg;

  // Architectural queue depth of write request, write data and read request queues
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  // Word store; the byte offset wraps on the store size, so keep this a power of two
  localparam int STORE_WORDS = 1024;
  localparam int STORE_AW    = $clog2(STORE_WORDS);
  localparam int STORE_BW    = STORE_AW + 2;

  // Decoupling queue between front and back
  localparam int ITEM_DEPTH = 2;
  localparam int ITEM_PW    = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
  localparam int ITEM_CW    = $clog2(ITEM_DEPTH + 1);

  // Result bundle queue ahead of the result port
  localparam int BUNDLE_DEPTH = 4;
  localparam int BUN_PW       = (BUNDLE_DEPTH > 1) ? $clog2(BUNDLE_DEPTH) : 1;
  localparam int BUN_CW       = $clog2(BUNDLE_DEPTH + 1);

  // Request codes
  localparam logic [1:0] REQ_WADDR = 2'd0;
  localparam logic [1:0] REQ_WDATA = 2'd1;
  localparam logic [1:0] REQ_RADDR = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // Result codes
  localparam logic [1:0] OUT_WRESP  = 2'd0;
  localparam logic [1:0] OUT_RDATA  = 2'd1;
  localparam logic [1:0] OUT_TXBYTE = 2'd2;

  // Burst kinds
  localparam logic [1:0] BURST_FIXED = 2'd0;
  localparam logic [1:0] BURST_INCR  = 2'd1;
  localparam logic [1:0] BURST_WRAP  = 2'd2;

  // Configuration register indexes
  localparam int         CFG_IDX_W        = 2;
  localparam logic [1:0] CFG_WINDOW_BASE  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_BYTES = 2'd1;
  localparam logic [1:0] CFG_TX_OFFSET    = 2'd2;

  localparam logic [12:0] WINDOW_BYTES_RST = 13'd4096;

  typedef struct packed {
    logic [31:0] window_base;
    logic [12:0] window_bytes;
    logic [11:0] tx_offset;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  txn_id;
    logic [31:0] start_addr;
    logic [7:0]  burst_len;
    logic [1:0]  beat_size;
    logic [1:0]  burst_kind;
    logic [31:0] write_word;
    logic [3:0]  byte_strobe;
    logic        write_last;
  } item_t;

  typedef struct packed {
    logic [3:0]  id;
    logic [31:0] addr;
    logic [7:0]  len;
    logic [1:0]  size;
    logic [1:0]  kind;
    logic [8:0]  beats;
  } burst_t;

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  strobe;
    logic        last;
  } beat_t;

  // Results of one tick, minus the read word
  typedef struct packed {
    logic       tx_v;
    logic       wr_v;
    logic [3:0] w_id;
    logic [7:0] tx_byte;
    logic       wr_err;
    logic       rd_v;
    logic [3:0] rd_id;
    logic       rd_err;
    logic       rd_last;
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic [31:0] rd_data;
  } bundle_t;

  // Store access of one tick: window-relative byte offsets
  typedef struct packed {
    logic                we;
    logic [STORE_BW-1:0] w_off;
    logic [31:0]         w_data;
    logic [3:0]          w_strb;
    logic [STORE_BW-1:0] r_off;
  } mem_req_t;

endpackage

// File: rtl/axbsm_chan_if.sv
// Channel interfaces: request input, result output and configuration write.
interface axbsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  txn_id;
  logic [31:0] start_addr;
  logic [7:0]  burst_len;
  logic [1:0]  beat_size;
  logic [1:0]  burst_kind;
  logic [31:0] write_word;
  logic [3:0]  byte_strobe;
  logic        write_last;

  modport source (
    output valid, req_type, txn_id, start_addr, burst_len, beat_size, burst_kind,
    output write_word, byte_strobe, write_last,
    input  ready
  );
  modport sink (
    input  valid, req_type, txn_id, start_addr, burst_len, beat_size, burst_kind,
    input  write_word, byte_strobe, write_last,
    output ready
  );
endinterface

interface axbsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [3:0]  out_id;
  logic [31:0] out_data;
  logic        out_error;
  logic        burst_last;
  logic        run_last;

  modport source (
    output valid, out_kind, out_id, out_data, out_error, burst_last, run_last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_id, out_data, out_error, burst_last, run_last,
    output ready
  );
endinterface

interface axbsm_cfg_if import axbsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/axi4_burst_slave_memory_tx.sv
// Top level of the AXI4 burst slave with word store and transmit-byte register.
//
// Channels: in_if carries request transactions (write address, write data beat,
// read address, tick), out_if carries results (write response, read beat,
// transmitted byte), cfg_if writes window_base, window_bytes and tx_offset.
// All use valid/ready; cfg_if is always ready and must only be written idle.
// Throughput: one request transaction per cycle while the front queue has room.
// The back end executes one request per cycle from the front queue, but a tick
// with results waits for a bundle slot; a tick leaves its results in one bundle,
// which holds the result port until all are sent. Tick results are registered
// with the store read, then pass the bundle queue before they are offered.
// The store is four byte-lane banks with one write and one read port each,
// so an unaligned beat is served in a single pass.
// Reset: burst queues and result queues empty, registers at their defaults;
// store contents are undefined until written. No clearing pass is run.
// Receiver stall: results wait in a four-bundle queue; once it is full, ticks
// that have results stall, the front queue fills and in_if.ready drops.
// Address and data transactions arriving at a full burst queue are dropped.
module axi4_burst_slave_memory_tx import axbsm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  axbsm_in_if.sink    in_if,
  axbsm_out_if.source out_if,
  axbsm_cfg_if.sink   cfg_if
);

  logic [31:0] window_base_r;
  logic [12:0] window_bytes_r;
  logic [11:0] tx_offset_r;
  cfg_t        cfg;
  logic        item_v, item_pop;
  item_t       item;
  logic        bun_v, bun_done;
  bundle_t     bun;

  // Configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r  <= '0;
      window_bytes_r <= WINDOW_BYTES_RST;
      tx_offset_r    <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_WINDOW_BASE:  window_base_r  <= cfg_if.data;
        CFG_WINDOW_BYTES: window_bytes_r <= cfg_if.data[12:0];
        CFG_TX_OFFSET:    tx_offset_r    <= cfg_if.data[11:0];
        default: ;
      endcase
    end
  end

  assign cfg.window_base  = window_base_r;
  assign cfg.window_bytes = window_bytes_r;
  assign cfg.tx_offset    = tx_offset_r;

  axbsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .item_v   (item_v),
    .item     (item),
    .item_pop (item_pop)
  );

  axbsm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item_v   (item_v),
    .item     (item),
    .item_pop (item_pop),
    .bun_v    (bun_v),
    .bun      (bun),
    .bun_done (bun_done)
  );

  axbsm_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .bun_v    (bun_v),
    .bun      (bun),
    .bun_done (bun_done),
    .out_if   (out_if)
  );

endmodule

// File: rtl/axbsm_front.sv
// Front end: accepts request transactions, sorts out their payload and queues them.
module axbsm_front import axbsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  axbsm_in_if.sink in_if,
  output logic     item_v,
  output item_t    item,
  input  logic     item_pop
);

  item_t               fifo_r [ITEM_DEPTH];
  logic [ITEM_PW-1:0]  head_r, tail_r;
  logic [ITEM_CW-1:0]  count_r;
  item_t               cls_item;
  logic                push, pop;

  // Keep only the fields that the request kind carries
  always_comb begin
    cls_item          = '0;
    cls_item.req_type = in_if.req_type;
    unique case (in_if.req_type) inside
      REQ_WADDR, REQ_RADDR: begin
        cls_item.txn_id     = in_if.txn_id;
        cls_item.start_addr = in_if.start_addr;
        cls_item.burst_len  = in_if.burst_len;
        cls_item.beat_size  = in_if.beat_size;
        cls_item.burst_kind = in_if.burst_kind;
      end
      REQ_WDATA: begin
        cls_item.write_word  = in_if.write_word;
        cls_item.byte_strobe = in_if.byte_strobe;
        cls_item.write_last  = in_if.write_last;
      end
      default: ;
    endcase
  end

  assign in_if.ready = (count_r != ITEM_CW'(ITEM_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign pop         = item_pop && (count_r != '0);
  assign item_v      = (count_r != '0);
  assign item        = fifo_r[head_r];

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) tail_r <= (tail_r == ITEM_PW'(ITEM_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      if (pop)  head_r <= (head_r == ITEM_PW'(ITEM_DEPTH - 1)) ? '0 : head_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) fifo_r[tail_r] <= cls_item;
  end

endmodule

// File: rtl/axbsm_store.sv
// Word store as four byte-lane banks with unaligned access and write-to-read bypass.
module axbsm_store import axbsm_pkg::*; (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rd_data
);

  logic [7:0] lane_q [4];
  logic [1:0] rot_r;

  for (genvar ln = 0; ln < 4; ln++) begin : g_lane
    logic [7:0]          mem [STORE_WORDS];
    logic [1:0]          w_k;
    logic [STORE_AW-1:0] w_word, r_word;
    logic                w_en;
    logic [7:0]          w_byte;
    logic [7:0]          q_r, byp_r;
    logic                hit_r;

    // Beat byte landing on this lane, and the word it falls in
    always_comb begin
      w_k    = 2'(ln) - req.w_off[1:0];
      w_word = req.w_off[STORE_BW-1:2] + STORE_AW'(2'(ln) < req.w_off[1:0]);
      r_word = req.r_off[STORE_BW-1:2] + STORE_AW'(2'(ln) < req.r_off[1:0]);
      w_en   = req.we && req.w_strb[w_k];
      w_byte = req.w_data[8*w_k +: 8];
    end

    // Read-first bank; same-cycle write to the read word is bypassed
    always_ff @(posedge clk) begin
      q_r <= mem[r_word];
      if (w_en) mem[w_word] <= w_byte;
      hit_r <= w_en && (w_word == r_word);
      byp_r <= w_byte;
    end

    assign lane_q[ln] = hit_r ? byp_r : q_r;
  end

  always_ff @(posedge clk) begin
    rot_r <= req.r_off[1:0];
  end

  // Rotate lanes back to beat byte order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_data[8*i +: 8] = lane_q[rot_r + 2'(i)];
    end
  end

endmodule

// File: rtl/axbsm_back.sv
// Back end: burst queues, beat execution per tick, store access and result bundling.
module axbsm_back import axbsm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    item_v,
  input  item_t   item,
  output logic    item_pop,
  output logic    bun_v,
  output bundle_t bun,
  input  logic    bun_done
);

  burst_t             wrq_r [QUEUE_DEPTH];
  beat_t              wdq_r [QUEUE_DEPTH];
  burst_t             rdq_r [QUEUE_DEPTH];
  logic [QPW-1:0]     wr_head_r, wd_head_r, rd_head_r;
  logic [QCW-1:0]     wr_count_r, wd_count_r, rd_count_r;
  logic [BUN_CW-1:0]  credits_r;
  logic               stb_v_r;
  meta_t              stb_meta_r;

  burst_t             wr_b, rd_b, new_burst, wr_b_nxt, rd_b_nxt;
  beat_t              wd_b, new_beat;
  logic [32:0]        w_diff, r_diff;
  logic               w_ok, r_ok, w_tx;
  logic               wserve, rserve, w_done, r_last, n_any;
  logic [8:0]         w_beats;
  logic               is_waddr, is_wdata, is_raddr, is_tick;
  logic               fire, tick_fire;
  logic               wr_push, wd_push, rd_push, wr_pop, wd_pop, rd_pop;
  meta_t              meta_nxt;
  mem_req_t           mreq;
  logic [31:0]        mem_rdata;

  function automatic logic [QPW-1:0] q_inc(input logic [QPW-1:0] p);
    return (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [QPW-1:0] q_tail(input logic [QPW-1:0] head,
                                           input logic [QCW-1:0] cnt);
    logic [QPW:0] sum;
    sum = {1'b0, head} + (QPW+1)'(cnt);
    if (sum >= (QPW+1)'(QUEUE_DEPTH)) sum = sum - (QPW+1)'(QUEUE_DEPTH);
    return sum[QPW-1:0];
  endfunction

  // Next beat address: fixed bursts hold, incrementing and wrapping add the beat size
  function automatic logic [31:0] adv_addr(input logic [31:0] addr,
                                           input logic [1:0] size,
                                           input logic [1:0] kind);
    logic [31:0] res;
    res = addr;
    case (kind) inside
      BURST_INCR, BURST_WRAP: res = addr + {28'd0, 4'd1 << size};
      default: ;
    endcase
    return res;
  endfunction

  // Request decode
  always_comb begin
    is_waddr = 1'b0;
    is_wdata = 1'b0;
    is_raddr = 1'b0;
    is_tick  = 1'b0;
    unique case (item.req_type)
      REQ_WADDR: is_waddr = 1'b1;
      REQ_WDATA: is_wdata = 1'b1;
      REQ_RADDR: is_raddr = 1'b1;
      REQ_TICK:  is_tick  = 1'b1;
      default: ;
    endcase
  end

  // Head bursts, window checks and beat bookkeeping
  always_comb begin
    wr_b = wrq_r[wr_head_r];
    wd_b = wdq_r[wd_head_r];
    rd_b = rdq_r[rd_head_r];

    w_diff = {1'b0, wr_b.addr} - {1'b0, cfg.window_base};
    r_diff = {1'b0, rd_b.addr} - {1'b0, cfg.window_base};
    w_ok   = !w_diff[32] && (w_diff[31:0] < {19'd0, cfg.window_bytes});
    r_ok   = !r_diff[32] && (r_diff[31:0] < {19'd0, cfg.window_bytes});
    w_tx   = w_ok && (w_diff[31:0] == {20'd0, cfg.tx_offset});

    wserve  = (wr_count_r != '0) && (wd_count_r != '0);
    rserve  = (rd_count_r != '0);
    w_beats = wr_b.beats + 9'd1;
    w_done  = wd_b.last || (w_beats > {1'b0, wr_b.len});
    r_last  = (rd_b.beats == {1'b0, rd_b.len});
    n_any   = rserve || (wserve && (w_tx || w_done));

    wr_b_nxt       = wr_b;
    wr_b_nxt.beats = w_beats;
    wr_b_nxt.addr  = adv_addr(wr_b.addr, wr_b.size, wr_b.kind);
    rd_b_nxt       = rd_b;
    rd_b_nxt.beats = rd_b.beats + 9'd1;
    rd_b_nxt.addr  = adv_addr(rd_b.addr, rd_b.size, rd_b.kind);

    new_burst.id    = item.txn_id;
    new_burst.addr  = item.start_addr;
    new_burst.len   = item.burst_len;
    new_burst.size  = item.beat_size;
    new_burst.kind  = item.burst_kind;
    new_burst.beats = '0;
    new_beat.word   = item.write_word;
    new_beat.strobe = item.byte_strobe;
    new_beat.last   = item.write_last;
  end

  // Issue: a tick with results waits for a free bundle slot
  assign fire      = item_v && (!is_tick || !n_any || (credits_r < BUN_CW'(BUNDLE_DEPTH)));
  assign tick_fire = fire && is_tick;
  assign item_pop  = fire;

  // Full queues drop the transaction
  assign wr_push = fire && is_waddr && (wr_count_r != QCW'(QUEUE_DEPTH));
  assign wd_push = fire && is_wdata && (wd_count_r != QCW'(QUEUE_DEPTH));
  assign rd_push = fire && is_raddr && (rd_count_r != QCW'(QUEUE_DEPTH));
  assign wd_pop  = tick_fire && wserve;
  assign wr_pop  = wd_pop && w_done;
  assign rd_pop  = tick_fire && rserve && r_last;

  // Store access of this tick
  always_comb begin
    mreq.we     = wd_pop && w_ok && !w_tx;
    mreq.w_off  = w_diff[STORE_BW-1:0];
    mreq.w_data = wd_b.word;
    mreq.w_strb = wd_b.strobe;
    mreq.r_off  = r_diff[STORE_BW-1:0];
  end

  axbsm_store u_store (
    .clk     (clk),
    .req     (mreq),
    .rd_data (mem_rdata)
  );

  // Results of this tick
  always_comb begin
    meta_nxt.tx_v    = wserve && w_tx;
    meta_nxt.wr_v    = wserve && w_done;
    meta_nxt.w_id    = wr_b.id;
    meta_nxt.tx_byte = wd_b.word[7:0];
    meta_nxt.wr_err  = !w_ok;
    meta_nxt.rd_v    = rserve;
    meta_nxt.rd_id   = rd_b.id;
    meta_nxt.rd_err  = !r_ok;
    meta_nxt.rd_last = r_last;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_head_r  <= '0;
      wd_head_r  <= '0;
      rd_head_r  <= '0;
      wr_count_r <= '0;
      wd_count_r <= '0;
      rd_count_r <= '0;
      credits_r  <= '0;
      stb_v_r    <= 1'b0;
    end else begin
      if (wr_pop) wr_head_r <= q_inc(wr_head_r);
      if (wd_pop) wd_head_r <= q_inc(wd_head_r);
      if (rd_pop) rd_head_r <= q_inc(rd_head_r);
      if (wr_push)     wr_count_r <= wr_count_r + 1'b1;
      else if (wr_pop) wr_count_r <= wr_count_r - 1'b1;
      if (wd_push)     wd_count_r <= wd_count_r + 1'b1;
      else if (wd_pop) wd_count_r <= wd_count_r - 1'b1;
      if (rd_push)     rd_count_r <= rd_count_r + 1'b1;
      else if (rd_pop) rd_count_r <= rd_count_r - 1'b1;
      case ({tick_fire && n_any, bun_done})
        2'b10:   credits_r <= credits_r + 1'b1;
        2'b01:   credits_r <= credits_r - 1'b1;
        default: ;
      endcase
      stb_v_r <= tick_fire && n_any;
    end
  end

  // Queue contents and the bundle stage
  always_ff @(posedge clk) begin
    if (wr_push) wrq_r[q_tail(wr_head_r, wr_count_r)] <= new_burst;
    if (wd_push) wdq_r[q_tail(wd_head_r, wd_count_r)] <= new_beat;
    if (rd_push) rdq_r[q_tail(rd_head_r, rd_count_r)] <= new_burst;
    if (wd_pop) wrq_r[wr_head_r] <= wr_b_nxt;
    if (tick_fire && rserve) rdq_r[rd_head_r] <= rd_b_nxt;
    stb_meta_r <= meta_nxt;
  end

  // Read word arrives in the cycle after issue, with the bundle stage; out-of-window reads return zero
  assign bun_v        = stb_v_r;
  assign bun.meta     = stb_meta_r;
  assign bun.rd_data  = (stb_meta_r.rd_v && !stb_meta_r.rd_err) ? mem_rdata : 32'd0;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credits_r <= BUN_CW'(BUNDLE_DEPTH))
    else $error("bundle credits exceed queue depth");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_count_r <= QCW'(QUEUE_DEPTH)) && (wd_count_r <= QCW'(QUEUE_DEPTH)) &&
    (rd_count_r <= QCW'(QUEUE_DEPTH)))
    else $error("burst queue overfilled");

  a_bundle_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_fire && n_any) |=> (stb_v_r && credits_r != '0))
    else $error("tick results lost before bundling");

  a_wresp_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pop |-> (wd_pop && wr_count_r != '0))
    else $error("write response without a served beat");

endmodule

// File: rtl/axbsm_outq.sv
// Result bundle queue and serializer onto the result channel.
module axbsm_outq import axbsm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          bun_v,
  input  bundle_t       bun,
  output logic          bun_done,
  axbsm_out_if.source   out_if
);

  localparam int SEL_TX = 0;
  localparam int SEL_WR = 1;
  localparam int SEL_RD = 2;

  bundle_t            fifo_r [BUNDLE_DEPTH];
  logic [BUN_PW-1:0]  head_r, tail_r;
  logic [BUN_CW-1:0]  count_r;
  logic [2:0]         sent_r;
  bundle_t            hd;
  logic [2:0]         pend, sel;
  logic               xfer, last;

  assign hd = fifo_r[head_r];

  // Pick the first pending result of the head bundle in the order tx byte, response, read beat
  always_comb begin
    pend = {hd.meta.rd_v, hd.meta.wr_v, hd.meta.tx_v} & ~sent_r;
    sel  = '0;
    if (pend[SEL_TX])      sel[SEL_TX] = 1'b1;
    else if (pend[SEL_WR]) sel[SEL_WR] = 1'b1;
    else                   sel[SEL_RD] = 1'b1;
    last = ((pend & ~sel) == '0);

    out_if.out_id     = hd.meta.w_id;
    out_if.out_data   = 32'd0;
    out_if.out_error  = 1'b0;
    out_if.burst_last = 1'b0;
    if (sel[SEL_TX]) begin
      out_if.out_kind = OUT_TXBYTE;
      out_if.out_data = {24'd0, hd.meta.tx_byte};
    end else if (sel[SEL_WR]) begin
      out_if.out_kind  = OUT_WRESP;
      out_if.out_error = hd.meta.wr_err;
    end else begin
      out_if.out_kind   = OUT_RDATA;
      out_if.out_id     = hd.meta.rd_id;
      out_if.out_data   = hd.rd_data;
      out_if.out_error  = hd.meta.rd_err;
      out_if.burst_last = hd.meta.rd_last;
    end
    out_if.run_last = last;
  end

  assign out_if.valid = (count_r != '0);
  assign xfer         = out_if.valid && out_if.ready;
  assign bun_done     = xfer && last;

  // Pointers and per-bundle progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      sent_r  <= '0;
    end else begin
      if (bun_v) tail_r <= (tail_r == BUN_PW'(BUNDLE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      if (bun_done) begin
        head_r <= (head_r == BUN_PW'(BUNDLE_DEPTH - 1)) ? '0 : head_r + 1'b1;
        sent_r <= '0;
      end else if (xfer) begin
        sent_r <= sent_r | sel;
      end
      case ({bun_v, bun_done})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (bun_v) fifo_r[tail_r] <= bun;
  end

endmodule
